>>> rtl/core/aaip_pkg.sv
`default_nettype none
// ============================================================================
// aaip_pkg - shared types and constants of the advertising interval policy
// Mode codes, register map, reset values and the cycle to interval mapping.
// ============================================================================
package aaip_pkg;

   // Advertising mode
   typedef enum logic [1:0] {
      MODE_SAFE       = 2'd0,
      MODE_FIXED      = 2'd1,
      MODE_MOVING     = 2'd2,
      MODE_STATIONARY = 2'd3
   } mode_type;

   // Operation codes of the request word
   localparam logic OP_START  = 1'b0;
   localparam logic OP_SAMPLE = 1'b1;

   // Register map, index = byte address / 4
   localparam int unsigned CSR_ADDR_W = 5;
   localparam int unsigned CSR_DATA_W = 32;
   typedef enum logic [2:0] {
      REG_ADAPTIVE_POLICY     = 3'd0,
      REG_SAFE_MODE           = 3'd1,
      REG_MOVING_CYCLE_MS     = 3'd2,
      REG_STATIONARY_CYCLE_MS = 3'd3,
      REG_QUIET_TIMEOUT_MS    = 3'd4,
      REG_MOTION_THRESHOLD_MG = 3'd5,
      REG_TEMP_DELTA_X100     = 3'd6,
      REG_UNUSED              = 3'd7
   } reg_index_type;

   // Register reset values
   localparam logic        RST_ADAPTIVE_POLICY     = 1'b1;
   localparam logic        RST_SAFE_MODE           = 1'b0;
   localparam logic [15:0] RST_MOVING_CYCLE_MS     = 16'd1000;
   localparam logic [15:0] RST_STATIONARY_CYCLE_MS = 16'd3000;
   localparam logic [31:0] RST_QUIET_TIMEOUT_MS    = 32'd300000;
   localparam logic [15:0] RST_MOTION_THRESHOLD_MG = 16'd25;
   localparam logic [15:0] RST_TEMP_DELTA_X100     = 16'd50;

   // Timing constants
   localparam int unsigned TIME_W          = 48;
   localparam int unsigned QUIET_US_W      = 42;    // 32-bit ms times 1000
   localparam logic [9:0]  US_PER_MS       = 10'd1000;
   localparam logic [15:0] SAFE_CYCLE_MS   = 16'd10000;
   localparam logic [15:0] MIN_MOVING_MS   = 16'd100;

   // Interval mapping: units = cycle * 8 / 5, saturated
   localparam logic [14:0] MAX_INTERVAL_UNITS = 15'h4000;
   localparam logic [15:0] UNITS_SAT_CYCLE    = 16'd10240;  // 10240 * 8 / 5 = 0x4000
   localparam logic [15:0] DIV5_RECIP         = 16'hCCCD;   // ceil(2^18 / 5)
   localparam int unsigned DIV5_SHIFT         = 18;

   // Cycle in ms to advertising interval in 0.625 ms units.
   // Divide by 5 through the reciprocal; exact for dividends below 2^18.
   function automatic logic [14:0] interval_units(input logic [15:0] cycle_ms);
      logic [16:0] times8;
      logic [32:0] scaled;
      begin
         times8 = {cycle_ms, 1'b0} << 2;
         scaled = {16'd0, times8} * {17'd0, DIV5_RECIP};
         if (cycle_ms >= UNITS_SAT_CYCLE) begin
            interval_units = MAX_INTERVAL_UNITS;
         end else begin
            interval_units = scaled[DIV5_SHIFT +: 15];
         end
      end
   endfunction

endpackage
`default_nettype wire

>>> rtl/core/adaptive_advert_interval_policy.sv
`default_nettype none
// ============================================================================
// adaptive_advert_interval_policy - moving/stationary advertising cadence
// Start and sample words drive the advertising mode and cycle length.
// ============================================================================
// Each request word is processed combinationally and its response word is
// registered: a word can be accepted every cycle, and the response appears on
// the cycle after acceptance. The single stage is set by the 48-bit quiet-time
// subtract and compare feeding the mode update and the divide-by-5 of the
// interval mapping. The response register holds while rsp_stall is high and
// req_stall follows it, so back-to-back words pass when the output is taken.
// A start word (operation 0) picks safe, fixed or moving mode from the
// registers; sample words (operation 1) run the moving/stationary policy.
// Cycle registers take effect at the next start or mode change. The quiet
// timeout is converted to microseconds when written over the APB port.

module adaptive_advert_interval_policy (
   input  wire logic                           clock,
   input  wire logic                           reset,
   // request channel
   input  wire logic                           req_valid,
   output logic                                req_stall,
   input  wire logic                           req_operation,
   input  wire logic [47:0]                    req_now_us,
   input  wire logic [15:0]                    req_rms_level_mg,
   input  wire logic signed [15:0]             req_temp_one_x100,
   input  wire logic signed [15:0]             req_temp_two_x100,
   // response channel
   output logic                                rsp_valid,
   input  wire logic                           rsp_stall,
   output logic [1:0]                          rsp_mode,
   output logic [15:0]                         rsp_cycle_ms,
   output logic [14:0]                         rsp_interval_units,
   output logic                                rsp_interval_changed,
   // configuration port
   input  wire logic                           csr_psel,
   input  wire logic                           csr_penable,
   input  wire logic                           csr_pwrite,
   input  wire logic [aaip_pkg::CSR_ADDR_W-1:0] csr_paddr,
   input  wire logic [aaip_pkg::CSR_DATA_W-1:0] csr_pwdata,
   output logic [aaip_pkg::CSR_DATA_W-1:0]      csr_prdata,
   output logic                                csr_pready
);

   // ---------------------------------------------------------------------
   // Configuration registers
   // ---------------------------------------------------------------------
   logic                              adaptive_policy_ff;
   logic                              safe_mode_ff;
   logic [15:0]                       moving_cycle_ms_ff;
   logic [15:0]                       stationary_cycle_ms_ff;
   logic [31:0]                       quiet_timeout_ms_ff;
   logic [aaip_pkg::QUIET_US_W-1:0]   quiet_timeout_us_ff;
   logic [15:0]                       motion_threshold_mg_ff;
   logic [15:0]                       temp_delta_x100_ff;

   logic                              csr_write;
   aaip_pkg::reg_index_type           csr_index;
   logic [aaip_pkg::QUIET_US_W-1:0]   quiet_us_in;

   assign csr_pready = 1'b1;
   assign csr_write  = csr_psel & csr_penable & csr_pwrite;
   assign csr_index  = aaip_pkg::reg_index_type'(csr_paddr[4:2]);
   assign quiet_us_in = {10'd0, csr_pwdata} * {32'd0, aaip_pkg::US_PER_MS};

   always_ff @(posedge clock) begin
      if (reset) begin
         adaptive_policy_ff     <= aaip_pkg::RST_ADAPTIVE_POLICY;
         safe_mode_ff           <= aaip_pkg::RST_SAFE_MODE;
         moving_cycle_ms_ff     <= aaip_pkg::RST_MOVING_CYCLE_MS;
         stationary_cycle_ms_ff <= aaip_pkg::RST_STATIONARY_CYCLE_MS;
         quiet_timeout_ms_ff    <= aaip_pkg::RST_QUIET_TIMEOUT_MS;
         quiet_timeout_us_ff    <= {10'd0, aaip_pkg::RST_QUIET_TIMEOUT_MS}
                                   * {32'd0, aaip_pkg::US_PER_MS};
         motion_threshold_mg_ff <= aaip_pkg::RST_MOTION_THRESHOLD_MG;
         temp_delta_x100_ff     <= aaip_pkg::RST_TEMP_DELTA_X100;
      end else if (csr_write) begin
         unique case (csr_index)
            aaip_pkg::REG_ADAPTIVE_POLICY:     adaptive_policy_ff <= csr_pwdata[0];
            aaip_pkg::REG_SAFE_MODE:           safe_mode_ff <= csr_pwdata[0];
            aaip_pkg::REG_MOVING_CYCLE_MS:     moving_cycle_ms_ff <= csr_pwdata[15:0];
            aaip_pkg::REG_STATIONARY_CYCLE_MS: stationary_cycle_ms_ff <= csr_pwdata[15:0];
            aaip_pkg::REG_QUIET_TIMEOUT_MS: begin
               quiet_timeout_ms_ff <= csr_pwdata;
               quiet_timeout_us_ff <= quiet_us_in;
            end
            aaip_pkg::REG_MOTION_THRESHOLD_MG: motion_threshold_mg_ff <= csr_pwdata[15:0];
            aaip_pkg::REG_TEMP_DELTA_X100:     temp_delta_x100_ff <= csr_pwdata[15:0];
            default: ;
         endcase
      end
   end

   // readback
   always_comb begin
      unique case (csr_index)
         aaip_pkg::REG_ADAPTIVE_POLICY:     csr_prdata = {31'd0, adaptive_policy_ff};
         aaip_pkg::REG_SAFE_MODE:           csr_prdata = {31'd0, safe_mode_ff};
         aaip_pkg::REG_MOVING_CYCLE_MS:     csr_prdata = {16'd0, moving_cycle_ms_ff};
         aaip_pkg::REG_STATIONARY_CYCLE_MS: csr_prdata = {16'd0, stationary_cycle_ms_ff};
         aaip_pkg::REG_QUIET_TIMEOUT_MS:    csr_prdata = quiet_timeout_ms_ff;
         aaip_pkg::REG_MOTION_THRESHOLD_MG: csr_prdata = {16'd0, motion_threshold_mg_ff};
         aaip_pkg::REG_TEMP_DELTA_X100:     csr_prdata = {16'd0, temp_delta_x100_ff};
         default:                           csr_prdata = '0;
      endcase
   end

   // ---------------------------------------------------------------------
   // Policy state
   // ---------------------------------------------------------------------
   aaip_pkg::mode_type    mode_ff, mode_in;
   logic [15:0]           cycle_ms_ff, cycle_ms_in;
   logic [47:0]           last_active_us_ff, last_active_us_in;
   logic signed [15:0]    ref_temp_one_ff, ref_temp_one_in;
   logic signed [15:0]    ref_temp_two_ff, ref_temp_two_in;
   logic                  ref_valid_ff, ref_valid_in;
   logic                  changed_in;

   logic                  req_accept;
   logic                  rsp_valid_ff;
   logic [1:0]            rsp_mode_ff;
   logic [15:0]           rsp_cycle_ms_ff;
   logic [14:0]           rsp_units_ff;
   logic                  rsp_changed_ff;

   // clamped cycle lengths
   logic [15:0]           eff_moving_ms;
   logic [15:0]           eff_stationary_ms;
   assign eff_moving_ms     = (moving_cycle_ms_ff < aaip_pkg::MIN_MOVING_MS)
                              ? aaip_pkg::MIN_MOVING_MS : moving_cycle_ms_ff;
   assign eff_stationary_ms = (stationary_cycle_ms_ff < eff_moving_ms)
                              ? eff_moving_ms : stationary_cycle_ms_ff;

   // motion and temperature events
   logic                  motion;
   logic signed [16:0]    diff_one, diff_two;
   logic [16:0]           abs_one, abs_two;
   logic                  temp_wake;
   assign motion   = req_rms_level_mg >= motion_threshold_mg_ff;
   assign diff_one = 17'(req_temp_one_x100) - 17'(ref_temp_one_ff);
   assign diff_two = 17'(req_temp_two_x100) - 17'(ref_temp_two_ff);
   assign abs_one  = diff_one[16] ? 17'(-diff_one) : 17'(diff_one);
   assign abs_two  = diff_two[16] ? 17'(-diff_two) : 17'(diff_two);
   assign temp_wake = ref_valid_ff &&
                      ((abs_one >= {1'b0, temp_delta_x100_ff}) ||
                       (abs_two >= {1'b0, temp_delta_x100_ff}));

   // quiet time: borrow bit flags time running backwards
   logic [48:0]           elapsed_us;
   logic                  quiet_expired;
   assign elapsed_us    = {1'b0, req_now_us} - {1'b0, last_active_us_ff};
   assign quiet_expired = !elapsed_us[48] &&
                          (elapsed_us[47:0] >= {6'd0, quiet_timeout_us_ff});

   // next state
   always_comb begin
      mode_in           = mode_ff;
      cycle_ms_in       = cycle_ms_ff;
      last_active_us_in = last_active_us_ff;
      ref_temp_one_in   = ref_temp_one_ff;
      ref_temp_two_in   = ref_temp_two_ff;
      ref_valid_in      = ref_valid_ff;
      changed_in        = 1'b0;
      if (req_operation == aaip_pkg::OP_START) begin
         priority if (safe_mode_ff) begin
            mode_in     = aaip_pkg::MODE_SAFE;
            cycle_ms_in = aaip_pkg::SAFE_CYCLE_MS;
         end else if (!adaptive_policy_ff) begin
            mode_in     = aaip_pkg::MODE_FIXED;
            cycle_ms_in = eff_moving_ms;
         end else begin
            mode_in     = aaip_pkg::MODE_MOVING;
            cycle_ms_in = eff_moving_ms;
         end
         last_active_us_in = req_now_us;
         ref_valid_in      = 1'b0;
      end else begin
         unique case (mode_ff)
            aaip_pkg::MODE_MOVING: begin
               ref_temp_one_in = req_temp_one_x100;
               ref_temp_two_in = req_temp_two_x100;
               ref_valid_in    = 1'b1;
               if (motion) begin
                  last_active_us_in = req_now_us;
               end else if (quiet_expired) begin
                  mode_in     = aaip_pkg::MODE_STATIONARY;
                  cycle_ms_in = eff_stationary_ms;
                  changed_in  = eff_stationary_ms != cycle_ms_ff;
               end
            end
            aaip_pkg::MODE_STATIONARY: begin
               if (motion || temp_wake) begin
                  last_active_us_in = req_now_us;
                  mode_in     = aaip_pkg::MODE_MOVING;
                  cycle_ms_in = eff_moving_ms;
                  changed_in  = eff_moving_ms != cycle_ms_ff;
               end
            end
            default: ;   // safe and fixed ignore samples
         endcase
      end
   end

   // handshake: output register parts the channels
   assign req_stall  = rsp_valid_ff & rsp_stall;
   assign req_accept = req_valid & ~req_stall;

   always_ff @(posedge clock) begin
      if (reset) begin
         mode_ff           <= aaip_pkg::MODE_SAFE;
         cycle_ms_ff       <= aaip_pkg::SAFE_CYCLE_MS;
         last_active_us_ff <= '0;
         ref_temp_one_ff   <= '0;
         ref_temp_two_ff   <= '0;
         ref_valid_ff      <= 1'b0;
      end else if (req_accept) begin
         mode_ff           <= mode_in;
         cycle_ms_ff       <= cycle_ms_in;
         last_active_us_ff <= last_active_us_in;
         ref_temp_one_ff   <= ref_temp_one_in;
         ref_temp_two_ff   <= ref_temp_two_in;
         ref_valid_ff      <= ref_valid_in;
      end
   end

   // response valid
   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else if (req_accept) begin
         rsp_valid_ff <= 1'b1;
      end else if (!rsp_stall) begin
         rsp_valid_ff <= 1'b0;
      end
   end

   // response payload
   always_ff @(posedge clock) begin
      if (req_accept) begin
         rsp_mode_ff     <= mode_in;
         rsp_cycle_ms_ff <= cycle_ms_in;
         rsp_units_ff    <= aaip_pkg::interval_units(cycle_ms_in);
         rsp_changed_ff  <= changed_in;
      end
   end

   // outputs
   always_comb begin
      rsp_valid            = rsp_valid_ff;
      rsp_mode             = rsp_mode_ff;
      rsp_cycle_ms         = rsp_cycle_ms_ff;
      rsp_interval_units   = rsp_units_ff;
      rsp_interval_changed = rsp_changed_ff;
   end

endmodule
`default_nettype wire

>>> verif/tb.sv
`timescale 1ns / 1ps
// ============================================================================
// tb - testbench of the adaptive advertising interval policy
// Sends start and sample words in random bursts against a stalling receiver,
// predicts every status word with a behavioral copy of the policy and compares
// mode, cycle, interval and changed flag field by field, in order.
// ============================================================================
module tb;

   localparam int unsigned IDLE_LIMIT  = 4000;   // cycles with no handshake at all
   localparam int unsigned HOLD_CYCLES = 400;    // long receiver hold-off
   localparam int unsigned MAX_REPORTS = 10;

   typedef struct {
      aaip_pkg::mode_type mode;
      logic [15:0]        cycle_ms;
      logic [14:0]        units;
      logic               changed;
   } status_type;

   // DUT ports, all inputs known from time zero
   logic                            clock                = 1'b0;
   logic                            reset                = 1'b1;
   logic                            req_valid            = 1'b0;
   logic                            req_stall;
   logic                            req_operation        = aaip_pkg::OP_START;
   logic [47:0]                     req_now_us           = '0;
   logic [15:0]                     req_rms_level_mg     = '0;
   logic signed [15:0]              req_temp_one_x100    = '0;
   logic signed [15:0]              req_temp_two_x100    = '0;
   logic                            rsp_valid;
   logic                            rsp_stall            = 1'b0;
   logic [1:0]                      rsp_mode;
   logic [15:0]                     rsp_cycle_ms;
   logic [14:0]                     rsp_interval_units;
   logic                            rsp_interval_changed;
   logic                            csr_psel             = 1'b0;
   logic                            csr_penable          = 1'b0;
   logic                            csr_pwrite           = 1'b0;
   logic [aaip_pkg::CSR_ADDR_W-1:0] csr_paddr            = '0;
   logic [aaip_pkg::CSR_DATA_W-1:0] csr_pwdata           = '0;
   logic [aaip_pkg::CSR_DATA_W-1:0] csr_prdata;
   logic                            csr_pready;

   // register mirror, starts at the reset values
   logic        cfg_adaptive   = aaip_pkg::RST_ADAPTIVE_POLICY;
   logic        cfg_safe       = aaip_pkg::RST_SAFE_MODE;
   logic [15:0] cfg_moving     = aaip_pkg::RST_MOVING_CYCLE_MS;
   logic [15:0] cfg_stationary = aaip_pkg::RST_STATIONARY_CYCLE_MS;
   logic [31:0] cfg_quiet      = aaip_pkg::RST_QUIET_TIMEOUT_MS;
   logic [15:0] cfg_motion     = aaip_pkg::RST_MOTION_THRESHOLD_MG;
   logic [15:0] cfg_delta      = aaip_pkg::RST_TEMP_DELTA_X100;

   // predicted policy state
   aaip_pkg::mode_type pol_mode;
   logic [15:0]        pol_cycle;
   logic [47:0]        pol_last_us;
   logic signed [15:0] pol_ref_one;
   logic signed [15:0] pol_ref_two;
   logic               pol_ref_ok;
   logic               pol_changed;

   status_type  expected_status[$];
   int unsigned mismatch_count = 0;
   int unsigned idle_cycles    = 0;

   // traffic shaping
   int unsigned burst_left   = 0;
   logic        gaps_on      = 1'b1;
   int unsigned stall_style  = 1;
   logic        hold_pending = 1'b0;

   adaptive_advert_interval_policy i_dut (
      .clock                (clock),
      .reset                (reset),
      .req_valid            (req_valid),
      .req_stall            (req_stall),
      .req_operation        (req_operation),
      .req_now_us           (req_now_us),
      .req_rms_level_mg     (req_rms_level_mg),
      .req_temp_one_x100    (req_temp_one_x100),
      .req_temp_two_x100    (req_temp_two_x100),
      .rsp_valid            (rsp_valid),
      .rsp_stall            (rsp_stall),
      .rsp_mode             (rsp_mode),
      .rsp_cycle_ms         (rsp_cycle_ms),
      .rsp_interval_units   (rsp_interval_units),
      .rsp_interval_changed (rsp_interval_changed),
      .csr_psel             (csr_psel),
      .csr_penable          (csr_penable),
      .csr_pwrite           (csr_pwrite),
      .csr_paddr            (csr_paddr),
      .csr_pwdata           (csr_pwdata),
      .csr_prdata           (csr_prdata),
      .csr_pready           (csr_pready)
   );

   always #5 clock = ~clock;

   // ---------------------------------------------------------------------------
   // Policy prediction
   // ---------------------------------------------------------------------------

   // cycle loaded for a mode, clamps applied at load time
   function automatic logic [15:0] policy_cycle(input aaip_pkg::mode_type m);
      logic [15:0] mv;
      mv = (cfg_moving < aaip_pkg::MIN_MOVING_MS) ? aaip_pkg::MIN_MOVING_MS : cfg_moving;
      case (m)
         aaip_pkg::MODE_SAFE:       return aaip_pkg::SAFE_CYCLE_MS;
         aaip_pkg::MODE_STATIONARY: return (cfg_stationary < mv) ? mv : cfg_stationary;
         default:                   return mv;
      endcase
   endfunction

   function automatic void enter_mode(input aaip_pkg::mode_type m);
      logic [15:0] c;
      if (m == pol_mode) return;
      pol_mode = m;
      c = policy_cycle(m);
      if (c != pol_cycle) begin
         pol_cycle   = c;
         pol_changed = 1'b1;
      end
   endfunction

   function automatic int unsigned temp_gap(input logic signed [15:0] a,
                                            input logic signed [15:0] b);
      int d;
      d = int'(a) - int'(b);
      return (d < 0) ? -d : d;
   endfunction

   // advance the policy by one request word, return its status word
   function automatic status_type next_status(input logic op, input logic [47:0] now,
                                              input logic [15:0] rms,
                                              input logic signed [15:0] t1,
                                              input logic signed [15:0] t2);
      status_type  s;
      logic        motion;
      logic        temp_moved;
      logic [31:0] raw_units;
      if (op == aaip_pkg::OP_START) begin
         if (cfg_safe) pol_mode = aaip_pkg::MODE_SAFE;
         else if (!cfg_adaptive) pol_mode = aaip_pkg::MODE_FIXED;
         else pol_mode = aaip_pkg::MODE_MOVING;
         pol_cycle   = policy_cycle(pol_mode);
         pol_changed = 1'b0;
         pol_last_us = now;
         pol_ref_ok  = 1'b0;
      end else if (pol_mode == aaip_pkg::MODE_MOVING ||
                   pol_mode == aaip_pkg::MODE_STATIONARY) begin
         motion     = (rms >= cfg_motion);
         temp_moved = pol_ref_ok && (temp_gap(t1, pol_ref_one) >= 32'(cfg_delta) ||
                                     temp_gap(t2, pol_ref_two) >= 32'(cfg_delta));
         if (pol_mode == aaip_pkg::MODE_MOVING) begin
            // references track every sample while moving
            pol_ref_one = t1;
            pol_ref_two = t2;
            pol_ref_ok  = 1'b1;
            if (motion) begin
               pol_last_us = now;
            end else if (now >= pol_last_us &&
                         64'(now - pol_last_us) >= 64'(cfg_quiet) * 64'd1000) begin
               enter_mode(aaip_pkg::MODE_STATIONARY);
            end
         end else if (motion || temp_moved) begin
            pol_last_us = now;
            enter_mode(aaip_pkg::MODE_MOVING);
         end
      end
      raw_units = ({16'd0, pol_cycle} * 32'd8) / 32'd5;
      if (raw_units > 32'h4000) raw_units = 32'h4000;
      s.mode      = pol_mode;
      s.cycle_ms  = pol_cycle;
      s.units     = raw_units[14:0];
      s.changed   = pol_changed;
      pol_changed = 1'b0;   // read and clear
      return s;
   endfunction

   // ---------------------------------------------------------------------------
   // Monitor: predict on request accept, check on response accept, watchdog
   // ---------------------------------------------------------------------------
   always @(posedge clock) begin
      status_type got;
      status_type want;
      logic       busy;
      busy = 1'b0;
      if (reset) begin
         pol_mode    = aaip_pkg::MODE_SAFE;
         pol_cycle   = aaip_pkg::SAFE_CYCLE_MS;
         pol_last_us = '0;
         pol_ref_one = '0;
         pol_ref_two = '0;
         pol_ref_ok  = 1'b0;
         pol_changed = 1'b0;
         expected_status.delete();
      end else begin
         if (req_valid && !req_stall) begin
            expected_status.push_back(next_status(req_operation, req_now_us,
               req_rms_level_mg, req_temp_one_x100, req_temp_two_x100));
            busy = 1'b1;
         end
         if (rsp_valid && !rsp_stall) begin
            busy         = 1'b1;
            got.mode     = aaip_pkg::mode_type'(rsp_mode);
            got.cycle_ms = rsp_cycle_ms;
            got.units    = rsp_interval_units;
            got.changed  = rsp_interval_changed;
            if (expected_status.size() == 0) begin
               mismatch_count++;
               if (mismatch_count <= MAX_REPORTS) begin
                  $write("%0t: status word with none pending: ", $time);
                  $display("mode %0d cycle %0d units %0d chg %0b",
                           got.mode, got.cycle_ms, got.units, got.changed);
               end
            end else begin
               want = expected_status.pop_front();
               if (got.mode !== want.mode || got.cycle_ms !== want.cycle_ms ||
                   got.units !== want.units || got.changed !== want.changed) begin
                  mismatch_count++;
                  if (mismatch_count <= MAX_REPORTS) begin
                     $write("%0t: status mismatch exp mode %0d cycle %0d units %0d chg %0b",
                            $time, want.mode, want.cycle_ms, want.units, want.changed);
                     $display(" / got mode %0d cycle %0d units %0d chg %0b",
                              got.mode, got.cycle_ms, got.units, got.changed);
                  end
               end
            end
         end
      end
      if (csr_psel && csr_penable && csr_pwrite && csr_pready) busy = 1'b1;
      // watchdog
      if (busy || reset) begin
         idle_cycles = 0;
      end else begin
         idle_cycles++;
         if (idle_cycles >= IDLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Receiver: stall pattern, plus one long hold-off on request
   // ---------------------------------------------------------------------------
   initial begin
      int unsigned beat;
      beat = 0;
      forever begin
         @(posedge clock);
         beat++;
         if (hold_pending) begin
            hold_pending = 1'b0;
            rsp_stall <= 1'b1;
            repeat (HOLD_CYCLES) @(posedge clock);
         end else begin
            case (stall_style)
               0:       rsp_stall <= 1'b0;
               1:       rsp_stall <= ($urandom_range(0, 3) == 0);
               2:       rsp_stall <= ($urandom_range(0, 1) == 1);
               default: rsp_stall <= ((beat % 11) inside {2, 3, 5, 8, 9});
            endcase
         end
      end
   end

   // ---------------------------------------------------------------------------
   // Stimulus helpers
   // ---------------------------------------------------------------------------

   // offer one request word, return at the edge where it is taken
   task automatic send_word(input logic op, input logic [47:0] now, input logic [15:0] rms,
                            input logic signed [15:0] t1, input logic signed [15:0] t2);
      int unsigned gap;
      if (burst_left == 0) begin
         burst_left = $urandom_range(1, 24);
         gap = ($urandom_range(0, 2) == 0) ? 0 : $urandom_range(1, 6);
         if (gaps_on && gap != 0) begin
            req_valid <= 1'b0;
            repeat (gap) @(posedge clock);
         end
      end
      burst_left--;
      req_valid         <= 1'b1;
      req_operation     <= op;
      req_now_us        <= now;
      req_rms_level_mg  <= rms;
      req_temp_one_x100 <= t1;
      req_temp_two_x100 <= t2;
      do @(posedge clock); while (req_stall);
   endtask

   // stop offering and wait until every status word has come back
   task automatic drain_status();
      req_valid <= 1'b0;
      @(posedge clock);
      while (expected_status.size() != 0) @(posedge clock);
      repeat (2) @(posedge clock);
   endtask

   // APB write: setup then access, mirror updated once it has landed
   task automatic write_register(input aaip_pkg::reg_index_type idx,
                                 input logic [31:0] value);
      csr_psel    <= 1'b1;
      csr_pwrite  <= 1'b1;
      csr_penable <= 1'b0;
      csr_paddr   <= {idx, 2'b00};
      csr_pwdata  <= value;
      @(posedge clock);
      csr_penable <= 1'b1;
      do @(posedge clock); while (!csr_pready);
      csr_psel    <= 1'b0;
      csr_penable <= 1'b0;
      csr_pwrite  <= 1'b0;
      case (idx)
         aaip_pkg::REG_ADAPTIVE_POLICY:     cfg_adaptive   = value[0];
         aaip_pkg::REG_SAFE_MODE:           cfg_safe       = value[0];
         aaip_pkg::REG_MOVING_CYCLE_MS:     cfg_moving     = value[15:0];
         aaip_pkg::REG_STATIONARY_CYCLE_MS: cfg_stationary = value[15:0];
         aaip_pkg::REG_QUIET_TIMEOUT_MS:    cfg_quiet      = value;
         aaip_pkg::REG_MOTION_THRESHOLD_MG: cfg_motion     = value[15:0];
         aaip_pkg::REG_TEMP_DELTA_X100:     cfg_delta      = value[15:0];
         default: ;
      endcase
      @(posedge clock);
   endtask

   // start, then a stream of mostly well-formed samples with rising time
   task automatic run_sample_stream(input int count);
      logic [47:0] now;
      logic [63:0] span;
      logic [15:0] rms;
      int          base_one;
      int          base_two;
      int          swing;
      int unsigned r;
      now = ($urandom_range(0, 1) == 1) ? 48'({$urandom, $urandom})
                                        : 48'($urandom_range(0, 100000));
      // time steps sized so the quiet timeout is crossed now and then
      span = 64'(cfg_quiet) * 64'd1000 / 64'd3 + 64'd2000;
      if (span > 64'h3FFF_FFFF_FFFF) span = 64'h3FFF_FFFF_FFFF;
      swing    = int'(cfg_delta) / 2 + 1;
      base_one = int'($urandom_range(0, 8000)) - 2000;
      base_two = int'($urandom_range(0, 8000)) - 2000;
      send_word(aaip_pkg::OP_START, now, 16'd0, 16'(base_one), 16'(base_two));
      for (int k = 0; k < count; k++) begin
         r = $urandom_range(0, 99);
         if (r < 3) begin
            send_word(aaip_pkg::OP_START, now, 16'($urandom), 16'($urandom),
                      16'($urandom));
         end else if (r < 8) begin
            // noise: anything at all, time included
            send_word(1'($urandom_range(0, 1)), 48'({$urandom, $urandom}), 16'($urandom),
                      16'($urandom), 16'($urandom));
         end else begin
            now = now + 48'({$urandom, $urandom} % (span + 64'd1));
            if (cfg_motion == 16'd0 || $urandom_range(0, 7) == 0)
               rms = 16'($urandom_range(32'(cfg_motion), 65535));
            else
               rms = 16'($urandom_range(0, 32'(cfg_motion) - 1));
            if ($urandom_range(0, 9) == 0) base_one = int'($urandom_range(0, 65535)) - 32768;
            if ($urandom_range(0, 9) == 0) base_two = int'($urandom_range(0, 65535)) - 32768;
            send_word(aaip_pkg::OP_SAMPLE, now, rms,
                      16'(base_one + int'($urandom_range(0, 2 * swing)) - swing),
                      16'(base_two + int'($urandom_range(0, 2 * swing)) - swing));
         end
      end
   endtask

   // ---------------------------------------------------------------------------
   // Tests
   // ---------------------------------------------------------------------------

   // samples before any start leave the block in safe mode
   task automatic test_sample_before_start();
      send_word(aaip_pkg::OP_SAMPLE, 48'd0, 16'hFFFF, 16'sh7FFF, 16'sh8000);
      send_word(aaip_pkg::OP_SAMPLE, 48'hFFFF_FFFF_FFFF, 16'd0, 16'sh8000, 16'sh7FFF);
   endtask

   // start picks safe, fixed or moving; fixed ignores samples; moving clamp
   task automatic test_start_modes();
      send_word(aaip_pkg::OP_START, 48'd5000, 16'd0, 16'sd0, 16'sd0);
      drain_status();
      write_register(aaip_pkg::REG_SAFE_MODE, 32'd1);
      send_word(aaip_pkg::OP_START, 48'd6000, 16'd0, 16'sd0, 16'sd0);
      drain_status();
      write_register(aaip_pkg::REG_SAFE_MODE, 32'd0);
      write_register(aaip_pkg::REG_ADAPTIVE_POLICY, 32'd0);
      send_word(aaip_pkg::OP_START, 48'd7000, 16'd0, 16'sd0, 16'sd0);
      send_word(aaip_pkg::OP_SAMPLE, 48'hFFFF_FFFF_FFFF, 16'hFFFF, 16'sh7FFF, 16'sh8000);
      drain_status();
      write_register(aaip_pkg::REG_ADAPTIVE_POLICY, 32'd1);
      write_register(aaip_pkg::REG_MOVING_CYCLE_MS, 32'd0);
      write_register(aaip_pkg::REG_STATIONARY_CYCLE_MS, 32'd0);
      send_word(aaip_pkg::OP_START, 48'd8000, 16'd0, 16'sd0, 16'sd0);
   endtask

   // quiet timeout, wake on temperature and motion, time going backwards,
   // stationary clamp, delayed effect of cycle registers, interval saturation
   task automatic test_quiet_and_wake();
      drain_status();
      write_register(aaip_pkg::REG_MOVING_CYCLE_MS, 32'd500);
      write_register(aaip_pkg::REG_STATIONARY_CYCLE_MS, 32'd20000);
      write_register(aaip_pkg::REG_QUIET_TIMEOUT_MS, 32'd5);
      write_register(aaip_pkg::REG_MOTION_THRESHOLD_MG, 32'd25);
      write_register(aaip_pkg::REG_TEMP_DELTA_X100, 32'd50);
      send_word(aaip_pkg::OP_START, 48'd1_000_000, 16'd0, 16'sd0, 16'sd0);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_003_000, 16'd10, 16'sd2000, 16'sd2100);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_006_000, 16'd24, 16'sd2000, 16'sd2100);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_007_000, 16'd0, 16'sd2049, 16'sd2051);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_008_000, 16'd0, 16'sd2000, 16'sd2150);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_013_000, 16'd0, 16'sd2000, 16'sd2100);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_013_500, 16'd25, 16'sd2000, 16'sd2100);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_000_000, 16'd0, 16'sd2000, 16'sd2100);
      drain_status();
      // stationary cycle clamps to the moving one: no change flagged
      write_register(aaip_pkg::REG_STATIONARY_CYCLE_MS, 32'd0);
      write_register(aaip_pkg::REG_QUIET_TIMEOUT_MS, 32'd0);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_020_000, 16'd0, 16'sd2000, 16'sd2100);
      drain_status();
      // new moving cycle only shows at the next mode change
      write_register(aaip_pkg::REG_MOVING_CYCLE_MS, 32'd65535);
      send_word(aaip_pkg::OP_SAMPLE, 48'd1_030_000, 16'd100, 16'sd0, 16'sd0);
      drain_status();
      // zero delta: any valid reference wakes stationary
      write_register(aaip_pkg::REG_MOVING_CYCLE_MS, 32'd10239);
      write_register(aaip_pkg::REG_TEMP_DELTA_X100, 32'd0);
      send_word(aaip_pkg::OP_START, 48'd2_000_000, 16'd0, 16'sd0, 16'sd0);
      send_word(aaip_pkg::OP_SAMPLE, 48'd2_000_001, 16'd0, 16'sd0, 16'sd0);
      send_word(aaip_pkg::OP_SAMPLE, 48'd2_000_002, 16'd0, 16'sd0, 16'sd0);
   endtask

   // random register settings per phase, extremes first, varied traffic
   task automatic test_random_phases();
      logic        policy;
      logic        safe;
      logic [15:0] moving;
      logic [15:0] stat;
      logic [31:0] quiet;
      logic [15:0] motion;
      logic [15:0] delta;
      for (int phase = 0; phase < 12; phase++) begin
         if (phase == 0) begin
            policy = 1'b1; safe = 1'b0; moving = '0; stat = '0;
            quiet = '0; motion = '0; delta = '0;
         end else if (phase == 1) begin
            policy = 1'b1; safe = 1'b0; moving = '1; stat = '1;
            quiet = '1; motion = '1; delta = '1;
         end else begin
            policy = ($urandom_range(0, 5) != 0);
            safe   = ($urandom_range(0, 7) == 0);
            case ($urandom_range(0, 5))
               0:       moving = 16'd0;
               1:       moving = 16'd99;
               2:       moving = 16'd10240;
               3:       moving = 16'hFFFF;
               default: moving = 16'($urandom_range(100, 4000));
            endcase
            case ($urandom_range(0, 4))
               0:       stat = 16'd0;
               1:       stat = 16'd10239;
               2:       stat = 16'hFFFF;
               default: stat = 16'($urandom);
            endcase
            case ($urandom_range(0, 5))
               0:       quiet = 32'd0;
               1:       quiet = 32'hFFFF_FFFF;
               2:       quiet = $urandom;
               default: quiet = $urandom_range(1, 40);
            endcase
            case ($urandom_range(0, 5))
               0:       motion = 16'd0;
               1:       motion = 16'hFFFF;
               default: motion = 16'($urandom_range(10, 3000));
            endcase
            case ($urandom_range(0, 5))
               0:       delta = 16'd0;
               1:       delta = 16'hFFFF;
               default: delta = 16'($urandom_range(5, 400));
            endcase
         end
         drain_status();
         write_register(aaip_pkg::REG_ADAPTIVE_POLICY, 32'(policy));
         write_register(aaip_pkg::REG_SAFE_MODE, 32'(safe));
         write_register(aaip_pkg::REG_MOVING_CYCLE_MS, 32'(moving));
         write_register(aaip_pkg::REG_STATIONARY_CYCLE_MS, 32'(stat));
         write_register(aaip_pkg::REG_QUIET_TIMEOUT_MS, quiet);
         write_register(aaip_pkg::REG_MOTION_THRESHOLD_MG, 32'(motion));
         write_register(aaip_pkg::REG_TEMP_DELTA_X100, 32'(delta));
         stall_style = phase % 4;
         gaps_on     = (phase % 3 != 2);
         run_sample_stream(120);
      end
   endtask

   // receiver holds off while the sender keeps offering back to back
   task automatic test_input_backpressure();
      drain_status();
      write_register(aaip_pkg::REG_ADAPTIVE_POLICY, 32'd1);
      write_register(aaip_pkg::REG_SAFE_MODE, 32'd0);
      write_register(aaip_pkg::REG_QUIET_TIMEOUT_MS, 32'd3);
      stall_style  = 0;
      gaps_on      = 1'b0;
      hold_pending = 1'b1;
      run_sample_stream(60);
      gaps_on     = 1'b1;
      stall_style = 1;
   endtask

   // ---------------------------------------------------------------------------
   // Sequence
   // ---------------------------------------------------------------------------
   initial begin
      repeat (2) @(posedge clock);
      reset <= 1'b0;
      test_sample_before_start();
      test_start_modes();
      test_quiet_and_wake();
      test_random_phases();
      test_input_backpressure();
      drain_status();
      repeat (4) @(posedge clock);
      if (mismatch_count == 0) begin
         $display("SCOREBOARD CLEAN");
      end else begin
         $display("SCOREBOARD MISMATCH");
      end
      $finish;
   end

endmodule

>>> adaptive_advert_interval_policy.f
rtl/core/aaip_pkg.sv
rtl/core/adaptive_advert_interval_policy.sv
verif/tb.sv
